// ===== design/skrf_pkg.sv =====
package skrf_pkg;

	// field widths and number format
	localparam int FRACTION_BITS = 16;
	localparam int RATE_W = 24;
	localparam int VAR_W = 32;
	localparam int DVR_W = VAR_W + 1;
	localparam int PROD_W = 2 * VAR_W;
	localparam int ACC_W = RATE_W + DVR_W + 1;
	localparam int CNT_W = $clog2(VAR_W + 1);
	localparam int CFG_IDX_W = 2;

	// rate limits
	localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
	localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

	// register reset values, saturated to the variance width
	localparam logic [63:0] MOTION_WIDE = 64'd4 << FRACTION_BITS;
	localparam logic [63:0] START_WIDE = 64'd1000 << FRACTION_BITS;
	localparam logic [VAR_W-1:0] MOTION_RESET =
		(MOTION_WIDE > {32'd0, {VAR_W{1'b1}}}) ? {VAR_W{1'b1}} : MOTION_WIDE[VAR_W-1:0];
	localparam logic [VAR_W-1:0] SENSOR_RESET = VAR_W'(64'd1 << (FRACTION_BITS - 1));
	localparam logic [VAR_W-1:0] START_RESET =
		(START_WIDE > {32'd0, {VAR_W{1'b1}}}) ? {VAR_W{1'b1}} : START_WIDE[VAR_W-1:0];

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_NOISE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_NOISE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_VAR = 2'd2;

	// input command codes
	localparam logic CMD_GYRO = 1'b0;
	localparam logic CMD_ENCODER = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic predict;
		logic mul_mean;
		logic mul_gyro;
		logic mul_var;
		logic div_mean_start;
		logic div_var_start;
		logic take_mean;
		logic take_var;
		logic zero_var;
		logic load_out;
	} skrf_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic first;
		logic d_zero;
		logic div_busy;
		logic out_full;
	} skrf_status_t;

endpackage

// ===== design/skrf_div.sv =====
module skrf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          wide,
	input  logic [skrf_pkg::PROD_W-1:0]   dividend,
	input  logic [skrf_pkg::DVR_W-1:0]    divisor,
	output logic                          busy,
	output logic [skrf_pkg::VAR_W-1:0]    quotient
);
	import skrf_pkg::*;

	logic [DVR_W-1:0] rem_q;
	logic [VAR_W-1:0] low_q;
	logic [VAR_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [DVR_W:0]   trial;
	logic [DVR_W:0]   diff;
	logic             ge;

	// one restoring step: bring down the next dividend bit and try the divisor
	always_comb begin
		trial = {rem_q, low_q[VAR_W-1]};
		diff = trial - {1'b0, divisor};
		ge = trial >= {1'b0, divisor};
	end

	// control: quotient width sets the step count, high dividend bits seed the remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= wide ? CNT_W'(VAR_W) : CNT_W'(RATE_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder, dividend and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			if (wide) begin
				rem_q <= {1'b0, dividend[PROD_W-1:VAR_W]};
				low_q <= dividend[VAR_W-1:0];
			end else begin
				rem_q <= dividend[RATE_W+DVR_W-1:RATE_W];
				low_q <= {dividend[RATE_W-1:0], {(VAR_W-RATE_W){1'b0}}};
			end
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
			low_q <= {low_q[VAR_W-2:0], 1'b0};
			quo_q <= {quo_q[VAR_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

	// a running division always has steps left
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0))
		else $error("divider busy with zero step count");

endmodule

// ===== design/skrf_dp.sv =====
module skrf_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  skrf_pkg::skrf_cmd_t                 cmd,
	output skrf_pkg::skrf_status_t              status,
	input  logic                                in_command,
	input  logic signed [skrf_pkg::RATE_W-1:0]  in_rate,
	input  logic                                cfg_write,
	input  logic [skrf_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [skrf_pkg::VAR_W-1:0]          cfg_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [skrf_pkg::RATE_W-1:0]  out_rate,
	output logic [skrf_pkg::VAR_W-1:0]          out_var
);
	import skrf_pkg::*;

	// configuration registers
	logic [VAR_W-1:0] motion_q;
	logic [VAR_W-1:0] sensor_q;
	logic [VAR_W-1:0] start_q;

	// filter state
	logic signed [RATE_W-1:0] est_q;
	logic [VAR_W-1:0]         var_q;
	logic signed [RATE_W-1:0] prev_q;
	logic signed [RATE_W-1:0] gyro_q;
	logic                     first_q;
	logic signed [RATE_W-1:0] sample_q;

	// working registers
	logic [DVR_W-1:0]         d_q;
	logic [PROD_W-1:0]        prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     neg_q;
	logic                     out_valid_q;
	logic signed [RATE_W-1:0] out_rate_q;
	logic [VAR_W-1:0]         out_var_q;

	logic signed [RATE_W+1:0] mean_sum;
	logic signed [RATE_W-1:0] mean_sat;
	logic [DVR_W-1:0]         var_sum;
	logic [VAR_W-1:0]         var_pred;
	logic [DVR_W-1:0]         d_next;
	logic signed [DVR_W-1:0]  mul_a;
	logic signed [DVR_W-1:0]  mul_b;
	logic signed [2*DVR_W-1:0] mul_p;
	logic [ACC_W-1:0]         mag;
	logic [PROD_W-1:0]        div_n;
	logic                     div_start;
	logic                     div_busy;
	logic [VAR_W-1:0]         quo;
	logic signed [RATE_W-1:0] mean_q_sat;

	// configuration writes, out of range indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_q <= MOTION_RESET;
			sensor_q <= SENSOR_RESET;
			start_q <= START_RESET;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				REG_MOTION_NOISE: motion_q <= cfg_value;
				REG_SENSOR_NOISE: sensor_q <= cfg_value;
				REG_START_VAR: start_q <= cfg_value;
				default: ;
			endcase
		end
	end

	// predict arithmetic with saturation, divisor from the predicted variance
	always_comb begin
		mean_sum = (RATE_W+2)'(est_q) + (RATE_W+2)'(sample_q)
			- (RATE_W+2)'(prev_q);
		if (!mean_sum[RATE_W+1] && (mean_sum[RATE_W:RATE_W-1] != 2'b00)) begin
			mean_sat = RATE_MAX;
		end else if (mean_sum[RATE_W+1] && (mean_sum[RATE_W:RATE_W-1] != 2'b11)) begin
			mean_sat = RATE_MIN;
		end else begin
			mean_sat = mean_sum[RATE_W-1:0];
		end
		var_sum = {1'b0, var_q} + {1'b0, motion_q};
		var_pred = var_sum[DVR_W-1] ? {VAR_W{1'b1}} : var_sum[VAR_W-1:0];
		d_next = {1'b0, var_pred} + {1'b0, sensor_q};
	end

	// shared multiplier, operands picked by the current step
	always_comb begin
		priority if (cmd.mul_mean) begin
			mul_a = signed'({1'b0, sensor_q});
			mul_b = DVR_W'(est_q);
		end else if (cmd.mul_gyro) begin
			mul_a = signed'({1'b0, var_q});
			mul_b = DVR_W'(gyro_q);
		end else begin
			mul_a = signed'({1'b0, var_q});
			mul_b = signed'({1'b0, sensor_q});
		end
		mul_p = mul_a * mul_b;
	end

	// rounded dividend for each division
	always_comb begin
		mag = acc_q[ACC_W-1] ? (~acc_q + ACC_W'(1)) : acc_q;
		if (cmd.div_var_start) begin
			div_n = prod_q + PROD_W'(d_q[DVR_W-1:1]);
		end else begin
			div_n = PROD_W'(mag) + PROD_W'(d_q[DVR_W-1:1]);
		end
		div_start = cmd.div_mean_start || cmd.div_var_start;
	end

	skrf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.wide(cmd.div_var_start),
		.dividend(div_n),
		.divisor(d_q),
		.busy(div_busy),
		.quotient(quo)
	);

	// sign restore and clamp of the mean quotient
	always_comb begin
		if (neg_q) begin
			mean_q_sat = (quo > VAR_W'(32'h0080_0000)) ? RATE_MIN : RATE_W'(0 - quo[RATE_W-1:0]);
		end else begin
			mean_q_sat = (quo > VAR_W'(RATE_MAX)) ? RATE_MAX : quo[RATE_W-1:0];
		end
	end

	// control state of the filter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			est_q <= '0;
			var_q <= START_RESET;
			prev_q <= '0;
			gyro_q <= '0;
		end else begin
			if (cmd.accept) begin
				if (in_command == CMD_GYRO) begin
					gyro_q <= in_rate;
				end else if (first_q) begin
					est_q <= in_rate;
					prev_q <= in_rate;
					var_q <= start_q;
					first_q <= 1'b0;
				end
			end
			if (cmd.predict) begin
				est_q <= mean_sat;
				var_q <= var_pred;
				prev_q <= sample_q;
			end
			if (cmd.take_mean) begin
				est_q <= mean_q_sat;
			end
			if (cmd.take_var) begin
				var_q <= quo;
			end
			if (cmd.zero_var) begin
				var_q <= '0;
			end
		end
	end

	// working registers of the update step
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= in_rate;
		end
		if (cmd.predict) begin
			d_q <= d_next;
		end
		if (cmd.mul_mean || cmd.mul_gyro || cmd.mul_var) begin
			prod_q <= mul_p[PROD_W-1:0];
		end
		if (cmd.mul_gyro) begin
			acc_q <= ACC_W'(signed'(prod_q[ACC_W-2:0]));
		end
		if (cmd.mul_var) begin
			acc_q <= acc_q + ACC_W'(signed'(prod_q[ACC_W-2:0]));
		end
		if (cmd.div_mean_start) begin
			neg_q <= acc_q[ACC_W-1];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_rate_q <= est_q;
			out_var_q <= var_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rate = out_rate_q;
	assign out_var = out_var_q;

	// status back to the controller
	always_comb begin
		status.first = first_q;
		status.d_zero = (d_q == '0);
		status.div_busy = div_busy;
		status.out_full = out_valid_q && !out_ready;
	end

endmodule

// ===== design/skrf_ctrl.sv =====
module skrf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_command,
	output logic                   in_ready,
	input  skrf_pkg::skrf_status_t status,
	output skrf_pkg::skrf_cmd_t    cmd
);
	import skrf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREDICT,
		S_CHECK,
		S_MUL_MEAN,
		S_MUL_GYRO,
		S_MUL_VAR,
		S_DIV_MEAN_LOAD,
		S_DIV_MEAN,
		S_DIV_VAR_LOAD,
		S_DIV_VAR,
		S_TAKE_VAR,
		S_ZERO,
		S_OUT
	} state_t;

	state_t state_q;

	// step commands decoded from the state
	always_comb begin
		cmd = '0;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: cmd.accept = in_valid;
			S_PREDICT: cmd.predict = 1'b1;
			S_MUL_MEAN: cmd.mul_mean = 1'b1;
			S_MUL_GYRO: cmd.mul_gyro = 1'b1;
			S_MUL_VAR: cmd.mul_var = 1'b1;
			S_DIV_MEAN_LOAD: cmd.div_mean_start = 1'b1;
			S_DIV_VAR_LOAD: begin
				cmd.take_mean = 1'b1;
				cmd.div_var_start = 1'b1;
			end
			S_TAKE_VAR: cmd.take_var = 1'b1;
			S_ZERO: cmd.zero_var = 1'b1;
			S_OUT: cmd.load_out = !status.out_full;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && (in_command == CMD_ENCODER) && !status.first) begin
						state_q <= S_PREDICT;
					end
				end
				S_PREDICT: state_q <= S_CHECK;
				S_CHECK: state_q <= status.d_zero ? S_ZERO : S_MUL_MEAN;
				S_MUL_MEAN: state_q <= S_MUL_GYRO;
				S_MUL_GYRO: state_q <= S_MUL_VAR;
				S_MUL_VAR: state_q <= S_DIV_MEAN_LOAD;
				S_DIV_MEAN_LOAD: state_q <= S_DIV_MEAN;
				S_DIV_MEAN: begin
					if (!status.div_busy) begin
						state_q <= S_DIV_VAR_LOAD;
					end
				end
				S_DIV_VAR_LOAD: state_q <= S_DIV_VAR;
				S_DIV_VAR: begin
					if (!status.div_busy) begin
						state_q <= S_TAKE_VAR;
					end
				end
				S_TAKE_VAR: state_q <= S_OUT;
				S_ZERO: state_q <= S_OUT;
				S_OUT: begin
					if (!status.out_full) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// divider is never left running while waiting for an item
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !status.div_busy)
		else $error("divider busy in idle");

	// a result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !status.out_full)
		else $error("output register overwritten");

	// the divider picks up every start
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_mean_start || cmd.div_var_start) |=> status.div_busy)
		else $error("divider did not start");

endmodule

// ===== design/scalar_kalman_rate_fusion_unit.sv =====
// channel | direction | handshake          | payload
// s       | in        | s_tvalid/s_tready  | s_tdata: sample_rate; s_tuser: command
// m       | out       | m_tvalid/m_tready  | m_tdata: filtered_rate, estimate_variance
// cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a gyro sample or the first encoder sample is accepted with s_tready staying high
// a later encoder sample holds s_tready low until its result is loaded into the output register;
// a nonzero divisor runs the bit-serial divider (24 quotient bits for the mean, 32 for the variance)
// one result waits in the output register; a stall on m holds the last step
// arst_n clears the filter state and loads the register reset values
module scalar_kalman_rate_fusion_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [23:0]                        s_tdata,   // [23:0] sample_rate
	input  logic                               s_tuser,   // [0] command
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [55:0]                        m_tdata,   // [23:0] filtered_rate, [55:24] estimate_variance
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [skrf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [skrf_pkg::VAR_W-1:0]         cfg_data
);
	import skrf_pkg::*;

	skrf_cmd_t    cmd;
	skrf_status_t status;
	logic signed [RATE_W-1:0] out_rate;
	logic [VAR_W-1:0]         out_var;

	assign cfg_ready = 1'b1;

	skrf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_command(s_tuser),
		.in_ready(s_tready),
		.status(status),
		.cmd(cmd)
	);

	skrf_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.in_command(s_tuser),
		.in_rate(s_tdata),
		.cfg_write(cfg_valid),
		.cfg_idx(cfg_index),
		.cfg_value(cfg_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_rate(out_rate),
		.out_var(out_var)
	);

	assign m_tdata = {out_var, out_rate};

endmodule

// ===== tb/scalar_kalman_rate_fusion_unit_tb.sv =====
module scalar_kalman_rate_fusion_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import skrf_pkg::*;

	localparam int LATENCY_CYCLES = 80;
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 50;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [VAR_W-1:0] VAR_FULL = '1;

	typedef struct {
		logic signed [RATE_W-1:0] rate;
		logic [VAR_W-1:0] variance;
	} fused_t;

	typedef enum {READY_ALWAYS, READY_PATTERN, READY_COIN, READY_HOLD} ready_mode_t;

	// filter state mirror: predicts each fused estimate and checks the output stream
	class kalman_rate_tracker;
		logic [VAR_W-1:0] motion_noise;
		logic [VAR_W-1:0] sensor_noise;
		logic [VAR_W-1:0] start_var;
		logic signed [RATE_W-1:0] mean;
		logic signed [RATE_W-1:0] prev_encoder;
		logic signed [RATE_W-1:0] gyro;
		logic [VAR_W-1:0] variance;
		logic awaiting_first;
		fused_t expected_fused[$];
		int unsigned failures;

		function new();
			motion_noise = MOTION_RESET;
			sensor_noise = SENSOR_RESET;
			start_var = START_RESET;
			mean = '0;
			prev_encoder = '0;
			gyro = '0;
			variance = START_RESET;
			awaiting_first = 1'b1;
			failures = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] index, logic [VAR_W-1:0] data);
			case (index)
				REG_MOTION_NOISE: motion_noise = data;
				REG_SENSOR_NOISE: sensor_noise = data;
				REG_START_VAR: start_var = data;
				default: ;
			endcase
		endfunction

		// one accepted sample: gyro caches, first encoder seeds, later encoders fuse
		function void note_sample(logic cmd, logic signed [RATE_W-1:0] rate);
			longint wide_mean;
			longint blend;
			logic [64:0] var_sum;
			logic [64:0] divisor;
			logic [64:0] magnitude;
			logic [64:0] quotient;
			fused_t result;
			if (cmd == CMD_GYRO) begin
				gyro = rate;
				return;
			end
			if (awaiting_first) begin
				mean = rate;
				prev_encoder = rate;
				variance = start_var;
				awaiting_first = 1'b0;
				return;
			end
			// predict: shift mean by encoder delta, grow variance
			wide_mean = longint'(mean) + longint'(rate) - longint'(prev_encoder);
			if (wide_mean > longint'(RATE_MAX))
				mean = RATE_MAX;
			else if (wide_mean < longint'(RATE_MIN))
				mean = RATE_MIN;
			else
				mean = wide_mean[RATE_W-1:0];
			var_sum = 65'(variance) + 65'(motion_noise);
			variance = (var_sum > 65'(VAR_FULL)) ? VAR_FULL : var_sum[VAR_W-1:0];
			// update: variance-weighted blend with the cached gyro rate
			divisor = 65'(variance) + 65'(sensor_noise);
			if (divisor == 0) begin
				variance = '0;
			end else begin
				blend = longint'(sensor_noise) * longint'(mean)
					+ longint'(variance) * longint'(gyro);
				if (blend < 0) begin
					magnitude = 65'(-blend);
					quotient = (magnitude + (divisor >> 1)) / divisor;
					mean = (quotient > 65'h80_0000) ? RATE_MIN : RATE_W'(0 - quotient);
				end else begin
					magnitude = 65'(blend);
					quotient = (magnitude + (divisor >> 1)) / divisor;
					mean = (quotient > 65'h7F_FFFF) ? RATE_MAX : quotient[RATE_W-1:0];
				end
				magnitude = 65'(variance) * 65'(sensor_noise);
				quotient = (magnitude + (divisor >> 1)) / divisor;
				variance = (quotient > 65'(VAR_FULL)) ? VAR_FULL : quotient[VAR_W-1:0];
			end
			prev_encoder = rate;
			result.rate = mean;
			result.variance = variance;
			expected_fused.push_back(result);
		endfunction

		// compare one output transaction with the oldest predicted estimate
		function void check_result(logic [55:0] data);
			fused_t want;
			logic signed [RATE_W-1:0] got_rate;
			logic [VAR_W-1:0] got_var;
			got_rate = data[RATE_W-1:0];
			got_var = data[RATE_W+VAR_W-1:RATE_W];
			if (expected_fused.size() == 0) begin
				$error("unexpected estimate: filtered_rate %0d, estimate_variance %0d",
					got_rate, got_var);
				failures++;
				return;
			end
			want = expected_fused.pop_front();
			if (got_rate !== want.rate) begin
				$error("filtered_rate mismatch: expected %0d, got %0d", want.rate, got_rate);
				failures++;
			end
			if (got_var !== want.variance) begin
				$error("estimate_variance mismatch: expected %0d, got %0d",
					want.variance, got_var);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VAR_W-1:0] cfg_data = '0;

	kalman_rate_tracker tracker = new();

	int burst_left = 4;
	int idle_cycles = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	int ready_seg_left = 0;
	logic [7:0] ready_pattern = 8'h01;
	logic signed [RATE_W-1:0] last_encoder = '0;

	scalar_kalman_rate_fusion_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// receiver backpressure, changes segment by segment
	always @(negedge clk) begin
		if (ready_seg_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			ready_seg_left = (ready_mode == READY_HOLD) ? $urandom_range(4, 50)
				: $urandom_range(8, 64);
			ready_pattern = 8'($urandom) | 8'h01;
		end
		ready_seg_left--;
		case (ready_mode)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_PATTERN: begin
				m_tready <= ready_pattern[0];
				ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
			end
			READY_COIN: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= 1'b0;
		endcase
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata);
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_sample(logic cmd, logic signed [RATE_W-1:0] rate);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= rate;
		do @(posedge clk); while (!s_tready);
		tracker.note_sample(cmd, rate);
		if (cmd == CMD_ENCODER)
			last_encoder = rate;
		// sender bursts separated by random gaps
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 80);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
		end
	endtask

	task automatic write_config(logic [CFG_IDX_W-1:0] index, logic [VAR_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_register(index, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every estimate is back and the block has gone quiet
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.expected_fused.size() != 0) @(posedge clk);
		repeat (LATENCY_CYCLES) @(posedge clk);
	endtask

	function automatic logic [VAR_W-1:0] pick_variance();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return VAR_FULL;
			2: return VAR_W'($urandom);
			default: return VAR_W'($urandom_range(0, 32'h0010_0000));
		endcase
	endfunction

	function automatic logic signed [RATE_W-1:0] pick_rate();
		case ($urandom_range(0, 9))
			0: return RATE_MAX;
			1: return RATE_MIN;
			2, 3, 4: return RATE_W'($urandom);
			default: return RATE_W'(last_encoder + $urandom_range(0, 4095) - 2048);
		endcase
	endfunction

	initial begin
		// reset
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// saturating setup: huge start and motion variance, tiny sensor noise
		write_config(REG_START_VAR, VAR_FULL);
		write_config(REG_MOTION_NOISE, VAR_FULL);
		write_config(REG_SENSOR_NOISE, VAR_W'(1));
		write_config(REG_SPARE, 32'h1234_5678);
		// gyro cached before the first encoder, then the seeding encoder
		send_sample(CMD_GYRO, RATE_MAX);
		send_sample(CMD_ENCODER, RATE_MIN);
		send_sample(CMD_ENCODER, RATE_MAX);
		send_sample(CMD_GYRO, RATE_MIN);
		send_sample(CMD_ENCODER, RATE_MIN);
		send_sample(CMD_ENCODER, RATE_MIN);
		send_sample(CMD_GYRO, RATE_W'(0));
		send_sample(CMD_ENCODER, RATE_W'(1));
		send_sample(CMD_GYRO, RATE_W'(-1));
		send_sample(CMD_ENCODER, RATE_W'(-1));
		send_sample(CMD_ENCODER, RATE_W'(0));
		settle();

		// no noise at all: variance collapses, then the divisor is zero
		write_config(REG_MOTION_NOISE, '0);
		write_config(REG_SENSOR_NOISE, '0);
		send_sample(CMD_GYRO, RATE_W'(12345));
		send_sample(CMD_ENCODER, RATE_W'(100));
		send_sample(CMD_ENCODER, RATE_MAX);
		send_sample(CMD_ENCODER, RATE_MIN);
		send_sample(CMD_GYRO, RATE_MIN);
		send_sample(CMD_ENCODER, RATE_W'(5));
		settle();

		// maximal sensor noise: estimate follows the encoder
		write_config(REG_SENSOR_NOISE, VAR_FULL);
		write_config(REG_START_VAR, '0);
		send_sample(CMD_GYRO, RATE_MAX);
		send_sample(CMD_ENCODER, RATE_MAX);
		send_sample(CMD_ENCODER, RATE_W'(-4096));
		send_sample(CMD_ENCODER, RATE_MIN);
		settle();

		// random phases, each under a fresh noise setting
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_config(REG_MOTION_NOISE, pick_variance());
			write_config(REG_SENSOR_NOISE, pick_variance());
			if ($urandom_range(0, 1) == 0)
				write_config(REG_START_VAR, pick_variance());
			if ($urandom_range(0, 3) == 0)
				write_config(REG_SPARE, VAR_W'($urandom));
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_sample(1'($urandom_range(0, 1)), pick_rate());
			settle();
		end

		if (tracker.failures == 0 && tracker.expected_fused.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
